FILE: rtl/rrmp_pkg.sv
package rrmp_pkg;

  localparam int NumFields = 25;
  localparam logic [15:0] HeaderEnd = 16'd67;

  // result kinds
  localparam logic [1:0] KindField   = 2'd0;
  localparam logic [1:0] KindVerdict = 2'd1;
  localparam logic [1:0] KindGate    = 2'd2;

  // moments
  localparam logic [1:0] MomRefl  = 2'd0;
  localparam logic [1:0] MomVel   = 2'd1;
  localparam logic [1:0] MomWidth = 2'd2;

  // header field numbers that are kept for the checks, and the two four-byte fields
  localparam logic [4:0] FldAzNum    = 5'd4;
  localparam logic [4:0] FldElNum    = 5'd7;
  localparam logic [4:0] FldSurvBins = 5'd12;
  localparam logic [4:0] FldDopBins  = 5'd13;
  localparam logic [4:0] FldReflPtr  = 5'd16;
  localparam logic [4:0] FldVelPtr   = 5'd17;
  localparam logic [4:0] FldWidthPtr = 5'd18;
  localparam logic [4:0] FldTime     = 5'd0;
  localparam logic [4:0] FldCalib    = 5'd15;

  // check limits
  localparam logic [15:0] AzMax       = 16'd400;
  localparam logic [15:0] ElMax       = 16'd25;
  localparam logic [15:0] SurvBinsMax = 16'd460;
  localparam logic [15:0] DopBinsMax  = 16'd920;
  localparam logic [15:0] PtrMin      = 16'd100;
  localparam logic [15:0] VelPtrMax   = 16'd560;
  localparam logic [15:0] WidthPtrMax = 16'd1480;

  // error mask bits
  localparam int ErrAz    = 0;
  localparam int ErrEl    = 1;
  localparam int ErrSurv  = 2;
  localparam int ErrDop   = 3;
  localparam int ErrRefl  = 4;
  localparam int ErrVel   = 5;
  localparam int ErrWidth = 6;

  // sub-result select bits of one queue entry, in emit order
  localparam int SelField   = 0;
  localparam int SelVerdict = 1;
  localparam int SelRefl    = 2;
  localparam int SelVel     = 3;
  localparam int SelWidth   = 4;

  localparam logic [6:0] FieldStart [NumFields] = '{
    7'd0,  7'd4,  7'd6,  7'd8,  7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd20,
    7'd22, 7'd24, 7'd26, 7'd28, 7'd30, 7'd32, 7'd36, 7'd38, 7'd40, 7'd42,
    7'd44, 7'd60, 7'd62, 7'd64, 7'd66
  };

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
    logic       first;
    logic       last;
  } fld_info_t;

  // one queue entry: everything one accepted byte produces
  typedef struct packed {
    logic [4:0]  sel;
    logic [4:0]  field_index;
    logic [31:0] field_value;
    logic [6:0]  error_mask;
    logic [9:0]  gate_refl;
    logic [9:0]  gate_vel;
    logic [9:0]  gate_width;
    logic [7:0]  gate_value;
  } entry_t;

  // header byte offset to field position
  function automatic fld_info_t field_info(input logic [6:0] off);
    fld_info_t  r;
    logic [6:0] len;
    r = '0;
    for (int i = 0; i < NumFields; i++) begin
      len = (i == int'(FldTime) || i == int'(FldCalib)) ? 7'd4 : 7'd2;
      if (off >= FieldStart[i] && off < FieldStart[i] + len) begin
        r.hit   = 1'b1;
        r.idx   = 5'(i);
        r.first = (off == FieldStart[i]);
        r.last  = (off == FieldStart[i] + len - 7'd1);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/rrmp_in_if.sv
interface rrmp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_req;
  logic [15:0] message_size;

  modport source (output valid, output data_byte, output start_req,
                  output message_size, input ready);
  modport sink (input valid, input data_byte, input start_req,
                input message_size, output ready);
endinterface

FILE: rtl/rrmp_out_if.sv
interface rrmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [4:0]  field_index;
  logic [31:0] field_value;
  logic        header_ok;
  logic [6:0]  error_mask;
  logic [1:0]  moment;
  logic [9:0]  gate_index;
  logic [7:0]  gate_value;
  logic        last;

  modport source (output valid, output result_kind, output field_index,
                  output field_value, output header_ok, output error_mask,
                  output moment, output gate_index, output gate_value,
                  output last, input ready);
  modport sink (input valid, input result_kind, input field_index,
                input field_value, input header_ok, input error_mask,
                input moment, input gate_index, input gate_value,
                input last, output ready);
endinterface

FILE: rtl/rrmp_front.sv
module rrmp_front (
  input  logic             clk,
  input  logic             rst,
  rrmp_in_if.sink          bytes,
  input  logic             full,
  output logic             push,
  output rrmp_pkg::entry_t entry
);

  logic [15:0] byte_offset;
  logic [31:0] field_accumulator;
  logic [15:0] azimuth_count;
  logic [15:0] elevation_count;
  logic [15:0] surveillance_gates;
  logic [15:0] doppler_gates;
  logic [15:0] reflectivity_offset;
  logic [15:0] velocity_offset;
  logic [15:0] width_offset;
  logic [15:0] size_seen;
  logic        header_passed;
  logic [16:0] refl_end;
  logic [16:0] vel_end;
  logic [16:0] width_end;

  logic                accept;
  logic [15:0]         off;
  logic                in_header;
  rrmp_pkg::fld_info_t finfo;
  logic [31:0]         field_accumulator_next;
  logic                emit_field;
  logic                emit_verdict;
  logic [6:0]          mask;
  logic                gates_on;
  logic [2:0]          hit;
  logic [15:0]         d_refl, d_vel, d_width;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && !full;

  assign off       = bytes.start_req ? 16'd0 : byte_offset;
  assign in_header = (off <= rrmp_pkg::HeaderEnd);
  assign finfo     = rrmp_pkg::field_info(off[6:0]);

  assign field_accumulator_next = finfo.first ? {24'd0, bytes.data_byte}
                                              : {field_accumulator[23:0], bytes.data_byte};
  assign emit_field   = in_header && finfo.hit && finfo.last;
  assign emit_verdict = (off == rrmp_pkg::HeaderEnd);

  always_comb begin
    mask = '0;
    mask[rrmp_pkg::ErrAz] = (azimuth_count == 16'd0) || (azimuth_count > rrmp_pkg::AzMax);
    mask[rrmp_pkg::ErrEl] = (elevation_count == 16'd0) ||
                            (elevation_count > rrmp_pkg::ElMax);
    mask[rrmp_pkg::ErrSurv] = (surveillance_gates > rrmp_pkg::SurvBinsMax);
    mask[rrmp_pkg::ErrDop]  = (doppler_gates > rrmp_pkg::DopBinsMax);
    mask[rrmp_pkg::ErrRefl] = (reflectivity_offset != 16'd0) &&
                              (reflectivity_offset != rrmp_pkg::PtrMin);
    mask[rrmp_pkg::ErrVel]  = (velocity_offset != 16'd0) &&
                              ((velocity_offset < rrmp_pkg::PtrMin) ||
                               (velocity_offset > rrmp_pkg::VelPtrMax));
    mask[rrmp_pkg::ErrWidth] = (width_offset != 16'd0) &&
                               ((width_offset < rrmp_pkg::PtrMin) ||
                                (width_offset > rrmp_pkg::WidthPtrMax) ||
                                (width_offset > size_seen));
  end

  // window tests; ends are registered, pointers settle long before byte 68
  assign gates_on = !in_header && header_passed;
  assign hit[0] = gates_on && (reflectivity_offset != 16'd0) &&
                  (off >= reflectivity_offset) && ({1'b0, off} < refl_end);
  assign hit[1] = gates_on && (velocity_offset != 16'd0) &&
                  (off >= velocity_offset) && ({1'b0, off} < vel_end);
  assign hit[2] = gates_on && (width_offset != 16'd0) &&
                  (off >= width_offset) && ({1'b0, off} < width_end);

  assign d_refl  = off - reflectivity_offset;
  assign d_vel   = off - velocity_offset;
  assign d_width = off - width_offset;

  always_comb begin
    entry             = '0;
    entry.sel         = {hit, emit_verdict, emit_field};
    entry.field_index = finfo.idx;
    entry.field_value = field_accumulator_next;
    entry.error_mask  = mask;
    entry.gate_refl   = d_refl[9:0];
    entry.gate_vel    = d_vel[9:0];
    entry.gate_width  = d_width[9:0];
    entry.gate_value  = bytes.data_byte;
  end

  assign push = accept && (|entry.sel);

  always_ff @(posedge clk) begin
    refl_end  <= {1'b0, reflectivity_offset} + {1'b0, surveillance_gates};
    vel_end   <= {1'b0, velocity_offset} + {1'b0, doppler_gates};
    width_end <= {1'b0, width_offset} + {1'b0, doppler_gates};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset         <= '0;
      field_accumulator   <= '0;
      azimuth_count       <= '0;
      elevation_count     <= '0;
      surveillance_gates  <= '0;
      doppler_gates       <= '0;
      reflectivity_offset <= '0;
      velocity_offset     <= '0;
      width_offset        <= '0;
      size_seen           <= '0;
      header_passed       <= 1'b0;
    end else if (accept) begin
      if (bytes.start_req) begin
        azimuth_count       <= '0;
        elevation_count     <= '0;
        surveillance_gates  <= '0;
        doppler_gates       <= '0;
        reflectivity_offset <= '0;
        velocity_offset     <= '0;
        width_offset        <= '0;
        size_seen           <= bytes.message_size;
        header_passed       <= 1'b0;
      end
      if (in_header && finfo.hit) begin
        field_accumulator <= field_accumulator_next;
      end
      if (emit_field) begin
        case (finfo.idx)
          rrmp_pkg::FldAzNum:    azimuth_count       <= field_accumulator_next[15:0];
          rrmp_pkg::FldElNum:    elevation_count     <= field_accumulator_next[15:0];
          rrmp_pkg::FldSurvBins: surveillance_gates  <= field_accumulator_next[15:0];
          rrmp_pkg::FldDopBins:  doppler_gates       <= field_accumulator_next[15:0];
          rrmp_pkg::FldReflPtr:  reflectivity_offset <= field_accumulator_next[15:0];
          rrmp_pkg::FldVelPtr:   velocity_offset     <= field_accumulator_next[15:0];
          rrmp_pkg::FldWidthPtr: width_offset        <= field_accumulator_next[15:0];
          default: ;
        endcase
      end
      if (emit_verdict) begin
        header_passed <= (mask == 7'd0);
      end
      if (off != 16'hFFFF) begin
        byte_offset <= off + 16'd1;
      end else begin
        byte_offset <= off;
      end
    end
  end

endmodule

FILE: rtl/rrmp_fifo.sv
module rrmp_fifo #(
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrmp_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output rrmp_pkg::entry_t head,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rrmp_pkg::entry_t mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/rrmp_back.sv
module rrmp_back (
  input  logic             clk,
  input  logic             rst,
  input  rrmp_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  rrmp_out_if.source       results
);

  logic [4:0] done;
  logic [4:0] rem;
  logic [4:0] pick;
  logic       pick_last;
  logic       load;

  assign rem       = head.sel & ~done;
  assign pick      = rem & (~rem + 5'd1);
  assign pick_last = ((rem & ~pick) == 5'd0);
  assign load      = !empty && (!results.valid || results.ready);
  assign pop       = load && pick_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= '0;
      results.valid <= 1'b0;
    end else begin
      if (load) begin
        done <= pick_last ? 5'd0 : (done | pick);
      end
      if (load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.field_index <= '0;
      results.field_value <= '0;
      results.header_ok   <= 1'b0;
      results.error_mask  <= '0;
      results.moment      <= rrmp_pkg::MomRefl;
      results.gate_index  <= '0;
      results.gate_value  <= '0;
      results.last        <= pick_last;
      if (pick[rrmp_pkg::SelField]) begin
        results.result_kind <= rrmp_pkg::KindField;
        results.field_index <= head.field_index;
        results.field_value <= head.field_value;
      end else if (pick[rrmp_pkg::SelVerdict]) begin
        results.result_kind <= rrmp_pkg::KindVerdict;
        results.header_ok   <= (head.error_mask == 7'd0);
        results.error_mask  <= head.error_mask;
      end else begin
        results.result_kind <= rrmp_pkg::KindGate;
        results.gate_value  <= head.gate_value;
        if (pick[rrmp_pkg::SelRefl]) begin
          results.moment     <= rrmp_pkg::MomRefl;
          results.gate_index <= head.gate_refl;
        end else if (pick[rrmp_pkg::SelVel]) begin
          results.moment     <= rrmp_pkg::MomVel;
          results.gate_index <= head.gate_vel;
        end else begin
          results.moment     <= rrmp_pkg::MomWidth;
          results.gate_index <= head.gate_width;
        end
      end
    end
  end

endmodule

FILE: rtl/radar_radial_message_parser.sv
// Channel   | Dir | Payload                                   | Request
// ----------+-----+-------------------------------------------+---------------------------
// bytes     | in  | data_byte, start_req, message_size        | one raw message byte
// results   | out | result_kind, field_index, field_value,    | one field, verdict or gate
//           |     | header_ok, error_mask, moment, gate_index,|
//           |     | gate_value, last                          |
//
// One byte is taken every cycle while the result queue has room; a byte that
// yields k results, which leave the output one after another (k is 0..3, usually 0 or 1).
// First result is written to the queue at the edge that takes its byte, and the output
// register loads it from the queue once that register is free.
// Reset (rst, synchronous) empties the queue and output and clears the parse state but the window ends.
// The output register lets a new result load in the cycle the old one is taken;
// a stalled output fills the queue, after which bytes are held off.
module radar_radial_message_parser #(
  parameter int QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  rrmp_in_if.sink     bytes,
  rrmp_out_if.source  results
);

  // front-to-back queue signals
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  rrmp_pkg::entry_t wr_entry;
  rrmp_pkg::entry_t head;

  // front: tracks offset, builds header fields, runs the checks and
  // the moment window tests, one byte per cycle while the queue has room
  rrmp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  // each entry holds every result of one byte
  rrmp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // back: splits an entry into its results, in field, verdict,
  // reflectivity, velocity, width order, and marks the last one
  rrmp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .results (results)
  );

endmodule
